// ===== design/btmx_pkg.sv =====
// Shared constants and the result record for the binary trie max-XOR block.
// No dependencies; used by the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package btmx_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_VALUES_DEF = 1024;

  // Fixed stream field widths
  localparam int FIELD_W   = 32;
  localparam int IN_DATA_W = FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;
  localparam int USER_W    = 1;

  typedef struct packed {
    logic [FIELD_W-1:0] best_xor;
    logic [FIELD_W-1:0] running_max;
    logic               pool_full;
  } btmx_result_t;

endpackage

`default_nettype wire

// ===== design/binary_trie_max_xor.sv =====
// Top level: binary trie maximum-XOR block with output register.
// Uses btmx_pkg, btmx_ctrl and btmx_node_ram.
//
//  channel  | signals                    | contents (low bits first)
//  ---------+----------------------------+----------------------------------
//  s_axis   | tvalid tready tdata tuser  | tdata: value[31:0]; tuser: new_set
//  m_axis   | tvalid tready tdata tuser  | tdata: best_xor, running_max;
//           |                            | tuser: pool_full
//
// One request at a time. Each makes one node pool access per trie level on the
// insert walk plus allocation, then one per level on the query walk, all through
// the single read port and the single write port of the RAM.
// After reset the INIT state writes the empty root before s_axis_tready rises.
// A held result in the output register does not block the next request; the
// controller waits only if a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_max_xor #(
  parameter int VALUE_BITS = btmx_pkg::VALUE_BITS_DEF,
  parameter int MAX_VALUES = btmx_pkg::MAX_VALUES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [btmx_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // value[31:0]
  input  wire logic [btmx_pkg::USER_W-1:0]       s_axis_tuser,   // new_set
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [btmx_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // best_xor, running_max
  output logic      [btmx_pkg::USER_W-1:0]       m_axis_tuser    // pool_full
);

  localparam int POOL_DEPTH = MAX_VALUES * VALUE_BITS + 1;
  localparam int NODE_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  logic                   res_valid;
  logic                   res_ready;
  btmx_pkg::btmx_result_t res;
  logic                   mem_we;
  logic [NODE_W-1:0]      mem_waddr;
  logic [2*NODE_W-1:0]    mem_wdata;
  logic                   mem_re;
  logic [NODE_W-1:0]      mem_raddr;
  logic [2*NODE_W-1:0]    mem_rdata;

  btmx_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .POOL_DEPTH (POOL_DEPTH),
    .NODE_W     (NODE_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata),
    .in_new_set (s_axis_tuser[0]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  btmx_node_ram #(
    .DEPTH  (POOL_DEPTH),
    .ADDR_W (NODE_W),
    .DATA_W (2 * NODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {res.running_max, res.best_xor};
      m_axis_tuser <= res.pool_full;
    end
  end

endmodule

`default_nettype wire

// ===== design/btmx_node_ram.sv =====
// Node pool memory: one entry per trie node holding both child indices.
// Single write port, single read port, registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module btmx_node_ram #(
  parameter int DEPTH  = 32769,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/btmx_ctrl.sv =====
// Trie walker: insert walk, node allocation, max-XOR query walk, set maximum.
// Drives the node pool RAM; uses btmx_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module btmx_ctrl #(
  parameter int VALUE_BITS = 32,
  parameter int POOL_DEPTH = 32769,
  parameter int NODE_W     = 16,
  parameter int CNT_W      = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request side
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [btmx_pkg::FIELD_W-1:0]   in_value,
  input  wire logic                           in_new_set,
  // result side
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output btmx_pkg::btmx_result_t              res,
  // node pool
  output logic                                mem_we,
  output logic [NODE_W-1:0]                   mem_waddr,
  output logic [2*NODE_W-1:0]                 mem_wdata,
  output logic                                mem_re,
  output logic [NODE_W-1:0]                   mem_raddr,
  input  wire logic [2*NODE_W-1:0]            mem_rdata
);

  localparam int PW = $clog2(VALUE_BITS + 1);
  localparam int EW = 2 * NODE_W;
  localparam logic [VALUE_BITS-1:0] TOP_BIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

  typedef enum logic [3:0] {
    INIT, IDLE, WALK_START, WALK, LINK, ALLOC, QUERY_START, QUERY, FINISH
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] mask;
  logic [VALUE_BITS-1:0] best;
  logic [VALUE_BITS-1:0] set_max;
  logic [CNT_W-1:0]      nodes_used;
  logic [NODE_W-1:0]     node;
  logic [EW-1:0]         stop_entry;
  logic [PW-1:0]         pos;
  logic                  ok;

  logic                  cur_bit;
  logic                  nxt_bit;
  logic [NODE_W-1:0]     rd_zero;
  logic [NODE_W-1:0]     rd_one;
  logic [NODE_W-1:0]     own;
  logic [NODE_W-1:0]     other;
  logic [NODE_W-1:0]     qnext;
  logic [NODE_W-1:0]     fresh;
  logic [NODE_W-1:0]     fresh_next;
  logic [CNT_W:0]        need_sum;
  logic                  fits;
  logic                  last_level;
  logic [VALUE_BITS-1:0] max_next;

  always_comb begin
    cur_bit    = |(value & mask);
    nxt_bit    = |(value & (mask >> 1));
    rd_zero    = mem_rdata[NODE_W-1:0];
    rd_one     = mem_rdata[EW-1:NODE_W];
    own        = cur_bit ? rd_one : rd_zero;
    other      = cur_bit ? rd_zero : rd_one;
    qnext      = (other != '0) ? other : own;
    fresh      = nodes_used[NODE_W-1:0];
    fresh_next = NODE_W'(nodes_used + CNT_W'(1));
    // nodes that the rest of the path needs, checked against the pool size
    need_sum   = (CNT_W+1)'(nodes_used) + (CNT_W+1)'(pos);
    fits       = need_sum <= (CNT_W+1)'(POOL_DEPTH);
    last_level = pos == PW'(1);
    max_next   = (ok && best > set_max) ? best : set_max;
  end

  assign in_ready  = state == IDLE;
  assign res_valid = state == FINISH;
  always_comb begin
    res.best_xor    = btmx_pkg::FIELD_W'(best);
    res.running_max = btmx_pkg::FIELD_W'(max_next);
    res.pool_full   = ~ok;
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      INIT: begin
        mem_we = 1'b1;
      end
      IDLE: begin
        mem_we = in_valid && in_new_set;  // empty the root
      end
      WALK_START: begin
        mem_re = 1'b1;
      end
      WALK: begin
        mem_re    = (own != '0) && !last_level;
        mem_raddr = own;
      end
      LINK: begin
        mem_we    = 1'b1;
        mem_waddr = node;
        mem_wdata = cur_bit ? {fresh, stop_entry[NODE_W-1:0]}
                            : {stop_entry[EW-1:NODE_W], fresh};
      end
      ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = fresh;
        if (!last_level) begin
          mem_wdata = nxt_bit ? {fresh_next, NODE_W'(0)} : {NODE_W'(0), fresh_next};
        end
      end
      QUERY_START: begin
        mem_re = nodes_used > CNT_W'(1);
      end
      QUERY: begin
        mem_re    = (qnext != '0) && !last_level;
        mem_raddr = qnext;
      end
      FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= INIT;
      nodes_used <= CNT_W'(1);
      set_max    <= '0;
      ok         <= 1'b0;
    end else begin
      unique case (state)
        INIT: begin
          state <= IDLE;
        end
        IDLE: begin
          if (in_valid) begin
            value <= in_value[VALUE_BITS-1:0];
            pos   <= PW'(VALUE_BITS);
            mask  <= TOP_BIT;
            node  <= '0;
            if (in_new_set) begin
              nodes_used <= CNT_W'(1);
              set_max    <= '0;
            end
            state <= WALK_START;
          end
        end
        WALK_START: begin
          state <= WALK;
        end
        WALK: begin
          if (own == '0) begin
            stop_entry <= mem_rdata;
            ok         <= fits;
            state      <= fits ? LINK : QUERY_START;
          end else if (last_level) begin
            ok    <= 1'b1;  // value already stored
            state <= QUERY_START;
          end else begin
            node <= own;
            pos  <= pos - PW'(1);
            mask <= mask >> 1;
          end
        end
        LINK: begin
          state <= ALLOC;
        end
        ALLOC: begin
          nodes_used <= nodes_used + CNT_W'(1);
          if (last_level) begin
            state <= QUERY_START;
          end else begin
            pos  <= pos - PW'(1);
            mask <= mask >> 1;
          end
        end
        QUERY_START: begin
          pos   <= PW'(VALUE_BITS);
          mask  <= TOP_BIT;
          best  <= '0;
          state <= (nodes_used > CNT_W'(1)) ? QUERY : FINISH;
        end
        QUERY: begin
          if (other != '0) begin
            best <= best | mask;
          end
          if (qnext == '0 || last_level) begin
            state <= FINISH;
          end else begin
            pos  <= pos - PW'(1);
            mask <= mask >> 1;
          end
        end
        FINISH: begin
          if (res_ready) begin
            set_max <= max_next;
            state   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/btmx_checker.sv =====
// Port-level checks for binary_trie_max_xor, attached by bind.
// Uses btmx_pkg for the stream widths.
`timescale 1ns / 1ps
`default_nettype none

module btmx_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [btmx_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [btmx_pkg::USER_W-1:0]     s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [btmx_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [btmx_pkg::USER_W-1:0]     m_axis_tuser
);

  localparam int FW = btmx_pkg::FIELD_W;

  // nothing to deliver straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // one request in flight: tready drops after every accepted request
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  // a stored value joins the set, so the set maximum covers its best XOR
  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[2*FW-1:FW] >= m_axis_tdata[FW-1:0])
    else $error("running_max below best_xor of an inserted value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for binary_trie_max_xor: directed table, then random sets of values.
// Needs btmx_pkg and the design files; keeps its own trie to predict results the table does not give.
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_BITS = btmx_pkg::VALUE_BITS_DEF;
  localparam int MAX_VALUES = btmx_pkg::MAX_VALUES_DEF;
  localparam int POOL_NODES = MAX_VALUES * VALUE_BITS + 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 2 * VALUE_BITS + 16;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_REPORTS = 30;

  typedef enum logic [2:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC,
    RX_TRICKLE
  } rx_mode_t;

  typedef struct packed {
    logic [31:0] value;
    logic        new_set;
    logic        typed;   // 1: expected result given in the row
    logic [31:0] best;
    logic [31:0] maxv;
    logic        full;
  } stim_row_t;

  localparam int DIRECTED_N = 24;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},  // first after reset
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},  // duplicate
    '{32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h8000_0001, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h7FFF_FFFE, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h0000_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h0000_FFFE, 1'b0, 1'b1, 32'h0000_0001, 32'h0000_0001, 1'b0},
    '{32'h0000_FFFC, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h0001_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},  // only itself stored
    '{32'hEDCB_A987, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b1, 32'h0000_0003, 32'h0000_0003, 1'b0},
    '{32'h0000_0004, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFE, 1'b0, 1'b1, 32'h0000_0001, 32'h0000_0001, 1'b0}
  };

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [btmx_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // value[31:0]
  logic [btmx_pkg::USER_W-1:0]     s_axis_tuser = '0;   // new_set
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [btmx_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // best_xor[31:0], running_max[63:32]
  logic [btmx_pkg::USER_W-1:0]     m_axis_tuser;        // pool_full

  binary_trie_max_xor #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_VALUES(MAX_VALUES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- trie mirror
  logic [15:0]            zero_link [POOL_NODES];
  logic [15:0]            one_link  [POOL_NODES];
  int                     nodes_taken;
  logic [31:0]            set_best;
  logic [31:0]            set_members [$];
  btmx_pkg::btmx_result_t pending_results [$];
  int                     errors = 0;

  function automatic logic [15:0] link_of(int node, logic b);
    if (node >= POOL_NODES) return 16'd0;
    return b ? one_link[node] : zero_link[node];
  endfunction

  function automatic void trie_clear();
    zero_link[0] = 16'd0;
    one_link[0]  = 16'd0;
    nodes_taken  = 1;
    set_best     = 32'd0;
  endfunction

  // returns 0 when the pool cannot take the nodes this value needs
  function automatic bit trie_add(logic [31:0] v);
    int          node;
    int          lvl;
    int          fresh;
    logic [15:0] nxt;
    node = 0;
    lvl = VALUE_BITS - 1;
    while (lvl >= 0) begin
      nxt = link_of(node, v[lvl]);
      if (nxt == 16'd0) break;
      node = int'(nxt);
      lvl--;
    end
    if (nodes_taken + lvl + 1 > POOL_NODES) return 1'b0;
    while (lvl >= 0) begin
      fresh = nodes_taken;
      nodes_taken++;
      zero_link[fresh] = 16'd0;
      one_link[fresh]  = 16'd0;
      if (v[lvl]) one_link[node] = 16'(fresh);
      else zero_link[node] = 16'(fresh);
      node = fresh;
      lvl--;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] trie_best_xor(logic [31:0] v);
    int          node;
    int          lvl;
    logic [31:0] acc;
    logic [15:0] other;
    logic [15:0] same;
    acc = 32'd0;
    node = 0;
    if (nodes_taken <= 1) return 32'd0;
    for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
      other = link_of(node, ~v[lvl]);
      if (other != 16'd0) begin
        acc[lvl] = 1'b1;
        node = int'(other);
      end else begin
        same = link_of(node, v[lvl]);
        if (same == 16'd0) break;
        node = int'(same);
      end
    end
    return acc;
  endfunction

  function automatic btmx_pkg::btmx_result_t predict_max_xor(logic [31:0] v, logic clear);
    btmx_pkg::btmx_result_t r;
    bit                     ok;
    if (clear) trie_clear();
    ok = trie_add(v);
    r.best_xor = trie_best_xor(v);
    if (ok && r.best_xor > set_best) set_best = r.best_xor;
    r.running_max = set_best;
    r.pool_full = ~ok;
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  int burst_left = 0;

  task automatic send_value(input logic [31:0] v, input logic clear, input bit typed,
                            input btmx_pkg::btmx_result_t typed_res);
    btmx_pkg::btmx_result_t r;
    int                     gap;
    int                     pick;
    r = predict_max_xor(v, clear);
    if (clear) set_members.delete();
    if (!r.pool_full) set_members.push_back(v);
    pending_results.push_back(typed ? typed_res : r);
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) gap = $urandom_range(0, 2);
      else if (pick < 9) gap = $urandom_range(3, 20);
      else gap = $urandom_range(21, 80);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= clear;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [31:0] next_set_value();
    logic [31:0] base;
    if (set_members.size() == 0) return $urandom;
    base = set_members[$urandom_range(0, set_members.size() - 1)];
    case ($urandom_range(0, 9))
      0: return base;                                    // duplicate
      1: return ~base;                                   // complement
      2: return base ^ (32'd1 << $urandom_range(0, 31));
      3: return base ^ ($urandom & 32'h0000_00FF);
      4: return 32'($urandom_range(0, 255));
      5: return $urandom | 32'hF000_0000;
      6: return $urandom & 32'h0FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                     row;
    int                     sent;
    int                     set_len;
    int                     k;
    logic                   clear;
    logic [31:0]            v;
    btmx_pkg::btmx_result_t typed_res;

    trie_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_N; row++) begin
      typed_res.best_xor    = DIRECTED_ROWS[row].best;
      typed_res.running_max = DIRECTED_ROWS[row].maxv;
      typed_res.pool_full   = DIRECTED_ROWS[row].full;
      send_value(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].new_set,
                 DIRECTED_ROWS[row].typed, typed_res);
    end

    // random sets: most open with new_set, a few are broken by a stray clear
    typed_res = '0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k < 6) set_len = $urandom_range(1, 8);
      else if (k < 9) set_len = $urandom_range(9, 40);
      else set_len = $urandom_range(41, 120);
      for (k = 0; k < set_len; k++) begin
        clear = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        v = (k == 0) ? $urandom : next_set_value();
        send_value(v, clear, 1'b0, typed_res);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_hold = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 4));
      rx_hold = $urandom_range(50, 400);
    end
    rx_hold--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: m_axis_tready <= ((rx_tick % 9) < 2);
      default:     m_axis_tready <= ((rx_tick % 97) == 0);  // long stalls
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    btmx_pkg::btmx_result_t oldest;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual %h / %h / %b", $time,
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]);
      end else begin
        oldest = pending_results.pop_front();
        check_field("best_xor", oldest.best_xor, m_axis_tdata[31:0]);
        check_field("running_max", oldest.running_max, m_axis_tdata[63:32]);
        check_field("pool_full", {31'd0, oldest.pool_full}, {31'd0, m_axis_tuser[0]});
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

// ===== binary_trie_max_xor.f =====
design/btmx_pkg.sv
design/btmx_node_ram.sv
design/btmx_ctrl.sv
design/binary_trie_max_xor.sv
design/btmx_checker.sv
tb/tb_top.sv
